### src/bpq_pkg.sv
// Shared types and codes for the bucketed priority queue.
package bpq_pkg;

  localparam int ELEM_IN_W = 32;
  localparam int PRIO_W    = 4;
  localparam int COUNT_W   = 9;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BADPRIO = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_BAD = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [ELEM_IN_W-1:0]   elem;
    logic [PRIO_W-1:0]      prio;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } fe_req_t;

endpackage

### src/bpq_if.sv
// Request and result channel interfaces.
interface bpq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bpq_pkg::ELEM_IN_W-1:0] elem;
  logic [bpq_pkg::PRIO_W-1:0]    priority_req;
  modport source (output valid, op, elem, priority_req, input ready);
  modport sink (input valid, op, elem, priority_req, output ready);
endinterface

interface bpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [bpq_pkg::ELEM_IN_W-1:0] removed_elem;
  logic [bpq_pkg::ELEM_IN_W-1:0] head_elem;
  logic [bpq_pkg::PRIO_W-1:0]    head_level;
  logic                          is_empty;
  logic [bpq_pkg::COUNT_W-1:0]   item_count;
  modport source (output valid, status, removed_elem, head_elem, head_level, is_empty,
                  item_count, input ready);
  modport sink (input valid, status, removed_elem, head_elem, head_level, is_empty,
                item_count, output ready);
endinterface

### src/bpq_front.sv
// Front end: accept and classify requests into a two-entry queue.
module bpq_front #(
  parameter int LEVELS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bpq_in_if.sink                       in_req,
  input  logic                         cfg_we,
  input  logic [bpq_pkg::PRIO_W-1:0]   cfg_wdata,
  input  logic                         pop,
  output bpq_pkg::fe_req_t             fe_out
);

  logic [bpq_pkg::PRIO_W-1:0] hl_r;
  bpq_pkg::req_t              q_r [2];
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  bpq_pkg::req_t              cls;
  logic                       push;
  logic                       do_pop;

  always_comb begin
    cls.elem = in_req.elem;
    cls.prio = in_req.priority_req;
    if (in_req.op) begin
      cls.kind = bpq_pkg::KIND_DEQ;
    end else if ((in_req.priority_req > hl_r) || (32'(in_req.priority_req) >= LEVELS)) begin
      cls.kind = bpq_pkg::KIND_BAD;
    end else begin
      cls.kind = bpq_pkg::KIND_ENQ;
    end
  end

  assign in_req.ready = (cnt_r != 2'd2);
  assign push         = in_req.valid && in_req.ready;
  assign do_pop       = pop && (cnt_r != 2'd0);
  assign fe_out.valid = (cnt_r != 2'd0);
  assign fe_out.req   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r     <= 4'd15;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        hl_r <= cfg_wdata;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### src/bpq_back.sv
// Back end: linked-slot queue sequencer and result register.
module bpq_back #(
  parameter int LEVELS    = 16,
  parameter int CAPACITY  = 256,
  parameter int ELEM_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bpq_pkg::fe_req_t fe_in,
  output logic             pop,
  bpq_out_if.source        out_res
);

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_E1   = 8'b0000_0010,
    ST_E2   = 8'b0000_0100,
    ST_D1   = 8'b0000_1000,
    ST_D2   = 8'b0001_0000,
    ST_H0   = 8'b0010_0000,
    ST_H1   = 8'b0100_0000,
    ST_H2   = 8'b1000_0000
  } state_t;

  logic [ELEM_BITS-1:0] slot_value [CAPACITY];
  logic [SLOT_W-1:0]    slot_next  [CAPACITY];
  logic [SLOT_W-1:0]    level_head [LEVELS];
  logic [SLOT_W-1:0]    level_tail [LEVELS];

  state_t               st_r, st_nxt;
  logic [LEVELS-1:0]    occ_r, occ_nxt;
  logic [SLOT_W-1:0]    free_head_r, free_head_nxt;
  logic                 free_valid_r, free_valid_nxt;
  logic [CNT_W-1:0]     fresh_r, fresh_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  bpq_pkg::status_t     status_r, status_nxt;
  logic [ELEM_BITS-1:0] removed_r, removed_nxt;
  logic [ELEM_BITS-1:0] elem_r, elem_nxt;
  logic [LVL_W-1:0]     prio_r, prio_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 was_occ_r, was_occ_nxt;

  logic [ELEM_BITS-1:0] rd_val_r;
  logic [SLOT_W-1:0]    rd_next_r, rd_head_r, rd_tail_r;

  logic                 val_re, next_re, head_re, tail_re;
  logic [SLOT_W-1:0]    val_ra, next_ra;
  logic [LVL_W-1:0]     head_ra, tail_ra;
  logic                 val_we, next_we, head_we, tail_we;
  logic [SLOT_W-1:0]    val_wa, next_wa, next_wd, head_wd, tail_wd;
  logic [LVL_W-1:0]     head_wa, tail_wa;

  logic                 out_valid_r;
  logic [1:0]           o_status_r;
  logic [31:0]          o_removed_r, o_head_r;
  logic [3:0]           o_level_r;
  logic                 o_empty_r;
  logic [8:0]           o_count_r;
  logic                 out_load;

  logic [LVL_W-1:0]     first_lvl;
  logic [SLOT_W-1:0]    new_slot;
  logic [CNT_W-1:0]     cnt_dec;
  logic [63:0]          elem_ext, head_ext, rem_ext;
  logic [31:0]          lvl_ext, cnt_ext, prio_ext;

  always_comb begin
    first_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (occ_r[i]) begin
        first_lvl = LVL_W'(i);
      end
    end
  end

  assign elem_ext = {32'b0, fe_in.req.elem};
  assign prio_ext = 32'(fe_in.req.prio);
  assign new_slot = free_valid_r ? free_head_r : fresh_r[SLOT_W-1:0];
  assign cnt_dec  = count_r - CNT_W'(1);
  assign out_load = !out_valid_r || out_res.ready;

  always_comb begin
    st_nxt         = st_r;
    occ_nxt        = occ_r;
    free_head_nxt  = free_head_r;
    free_valid_nxt = free_valid_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    removed_nxt    = removed_r;
    elem_nxt       = elem_r;
    prio_nxt       = prio_r;
    lvl_nxt        = lvl_r;
    slot_nxt       = slot_r;
    was_occ_nxt    = was_occ_r;
    pop     = 1'b0;
    val_re  = 1'b0; val_ra  = '0;
    next_re = 1'b0; next_ra = '0;
    head_re = 1'b0; head_ra = '0;
    tail_re = 1'b0; tail_ra = '0;
    val_we  = 1'b0; val_wa  = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0;
    tail_we = 1'b0; tail_wa = '0; tail_wd = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (fe_in.valid) begin
          pop         = 1'b1;
          removed_nxt = '0;
          elem_nxt    = elem_ext[ELEM_BITS-1:0];
          case (fe_in.req.kind)
            bpq_pkg::KIND_ENQ: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = bpq_pkg::STATUS_FULL;
                st_nxt     = ST_H0;
              end else begin
                status_nxt  = bpq_pkg::STATUS_OK;
                prio_nxt    = prio_ext[LVL_W-1:0];
                was_occ_nxt = occ_r[prio_ext[LVL_W-1:0]];
                next_re     = 1'b1;
                next_ra     = free_head_r;
                tail_re     = 1'b1;
                tail_ra     = prio_ext[LVL_W-1:0];
                st_nxt      = ST_E1;
              end
            end
            bpq_pkg::KIND_DEQ: begin
              if (occ_r == '0) begin
                status_nxt = bpq_pkg::STATUS_EMPTY;
                st_nxt     = ST_H0;
              end else begin
                status_nxt = bpq_pkg::STATUS_OK;
                lvl_nxt    = first_lvl;
                head_re    = 1'b1;
                head_ra    = first_lvl;
                tail_re    = 1'b1;
                tail_ra    = first_lvl;
                st_nxt     = ST_D1;
              end
            end
            default: begin
              status_nxt = bpq_pkg::STATUS_BADPRIO;
              st_nxt     = ST_H0;
            end
          endcase
        end
      end
      ST_E1: begin
        if (free_valid_r) begin
          free_head_nxt = rd_next_r;
        end else begin
          fresh_nxt = fresh_r + CNT_W'(1);
        end
        val_we  = 1'b1; val_wa  = new_slot;
        next_we = 1'b1; next_wa = new_slot; next_wd = '0;
        if (!was_occ_r) begin
          head_we = 1'b1; head_wa = prio_r; head_wd = new_slot;
        end
        tail_we = 1'b1; tail_wa = prio_r; tail_wd = new_slot;
        occ_nxt[prio_r] = 1'b1;
        count_nxt       = count_r + CNT_W'(1);
        free_valid_nxt  = (free_valid_r ? fresh_r : fresh_r + CNT_W'(1))
                          > (count_r + CNT_W'(1));
        slot_nxt        = new_slot;
        st_nxt          = was_occ_r ? ST_E2 : ST_H0;
      end
      ST_E2: begin
        next_we = 1'b1; next_wa = rd_tail_r; next_wd = slot_r;
        st_nxt  = ST_H0;
      end
      ST_D1: begin
        slot_nxt = rd_head_r;
        val_re   = 1'b1; val_ra  = rd_head_r;
        next_re  = 1'b1; next_ra = rd_head_r;
        st_nxt   = ST_D2;
      end
      ST_D2: begin
        removed_nxt = rd_val_r;
        if (rd_tail_r == slot_r) begin
          occ_nxt[lvl_r] = 1'b0;
        end else begin
          head_we = 1'b1; head_wa = lvl_r; head_wd = rd_next_r;
        end
        next_we        = 1'b1; next_wa = slot_r; next_wd = free_head_r;
        free_head_nxt  = slot_r;
        count_nxt      = cnt_dec;
        free_valid_nxt = fresh_r > cnt_dec;
        st_nxt         = ST_H0;
      end
      ST_H0: begin
        if (occ_r == '0) begin
          st_nxt = ST_H2;
        end else begin
          lvl_nxt = first_lvl;
          head_re = 1'b1;
          head_ra = first_lvl;
          st_nxt  = ST_H1;
        end
      end
      ST_H1: begin
        val_re = 1'b1; val_ra = rd_head_r;
        st_nxt = ST_H2;
      end
      ST_H2: begin
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      slot_value[val_wa] <= elem_r;
    end
    if (val_re) begin
      rd_val_r <= slot_value[val_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      slot_next[next_wa] <= next_wd;
    end
    if (next_re) begin
      rd_next_r <= slot_next[next_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      level_head[head_wa] <= head_wd;
    end
    if (head_re) begin
      rd_head_r <= level_head[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      level_tail[tail_wa] <= tail_wd;
    end
    if (tail_re) begin
      rd_tail_r <= level_tail[tail_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      occ_r        <= '0;
      free_head_r  <= '0;
      free_valid_r <= 1'b0;
      fresh_r      <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      occ_r        <= occ_nxt;
      free_head_r  <= free_head_nxt;
      free_valid_r <= free_valid_nxt;
      fresh_r      <= fresh_nxt;
      count_r      <= count_nxt;
      if (st_r == ST_H2 && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    elem_r    <= elem_nxt;
    prio_r    <= prio_nxt;
    lvl_r     <= lvl_nxt;
    slot_r    <= slot_nxt;
    was_occ_r <= was_occ_nxt;
  end

  assign head_ext = 64'(rd_val_r);
  assign rem_ext  = 64'(removed_r);
  assign lvl_ext  = 32'(lvl_r);
  assign cnt_ext  = 32'(count_r);

  always_ff @(posedge clk) begin
    if (st_r == ST_H2 && out_load) begin
      o_status_r  <= status_r;
      o_removed_r <= rem_ext[31:0];
      o_empty_r   <= (occ_r == '0);
      o_head_r    <= (occ_r == '0) ? 32'd0 : head_ext[31:0];
      o_level_r   <= (occ_r == '0) ? 4'd0 : lvl_ext[3:0];
      o_count_r   <= cnt_ext[8:0];
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = o_status_r;
  assign out_res.removed_elem = o_removed_r;
  assign out_res.head_elem    = o_head_r;
  assign out_res.head_level   = o_level_r;
  assign out_res.is_empty     = o_empty_r;
  assign out_res.item_count   = o_count_r;

endmodule

### src/bucketed_priority_queue.sv
// Top level of the bucketed priority queue.
// Strict-priority queue, one FIFO per level, level 0 most urgent.
// in_req carries a request: op 0 enqueues elem at priority_req, op 1 dequeues
// the head of the lowest occupied level. out_res carries one result per
// request: status, removed element, head element and level after the
// request, empty flag and item count.
// cfg_we/cfg_wdata write highest_level (reset 15); write only while idle.
// A request passes through the back end in steps: an enqueue runs 2 or 3
// memory steps, a dequeue 3, an error 1, then 2 or 3 steps read the new head
// through the level head table and the slot value memory (2 when empty).
// A two-entry request queue lets the front accept while the back works.
// Reset clears the level bits, counters and free list; no clearing pass.
// When out_res.ready is low the result holds and the back end waits
// before loading the next result; the front keeps accepting until full.
module bucketed_priority_queue #(
  parameter int LEVELS    = 16,
  parameter int CAPACITY  = 256,
  parameter int ELEM_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bpq_in_if.sink                     in_req,
  bpq_out_if.source                  out_res,
  input  logic                       cfg_we,
  input  logic [bpq_pkg::PRIO_W-1:0] cfg_wdata
);

  bpq_pkg::fe_req_t fe_req;
  logic             pop;

  bpq_front #(.LEVELS(LEVELS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .pop(pop), .fe_out(fe_req)
  );

  bpq_back #(.LEVELS(LEVELS), .CAPACITY(CAPACITY), .ELEM_BITS(ELEM_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .fe_in(fe_req), .pop(pop), .out_res(out_res)
  );

endmodule

### src/bpq_checker.sv
// Port-level checker for the bucketed priority queue and its bind.
module bpq_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_removed_elem,
  input logic        out_is_empty,
  input logic [8:0]  out_item_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_count))
    else $error("result dropped while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_item_count == 9'd0)))
    else $error("empty flag disagrees with count");

  a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bpq_pkg::STATUS_EMPTY |-> out_is_empty
      && out_removed_elem == 32'd0)
    else $error("empty dequeue reported with items");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bucketed_priority_queue bpq_port_checker u_bpq_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_res.valid), .out_ready(out_res.ready),
  .out_status(out_res.status), .out_removed_elem(out_res.removed_elem),
  .out_is_empty(out_res.is_empty), .out_item_count(out_res.item_count)
);
